### src/tsrb_pkg.sv
// Shared constants and request/response types for the timed setpoint ring buffer.
`timescale 1ns / 1ps
`default_nettype none

package tsrb_pkg;

  localparam int BufferPoints = 16;
  localparam int Joints       = 6;
  localparam int SlotW        = $clog2(BufferPoints);
  localparam int JointW       = 3;
  localparam int GoalDepth    = BufferPoints * Joints;
  localparam int GoalAw       = $clog2(GoalDepth);
  localparam int QueueDepth   = 2;
  localparam int QueuePtrW    = $clog2(QueueDepth);
  localparam int QueueCntW    = $clog2(QueueDepth + 1);

  typedef enum logic [1:0] {
    OP_START  = 2'd0,
    OP_WRITE  = 2'd1,
    OP_QUERY  = 2'd2,
    OP_UNUSED = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    ST_STARTED  = 3'd0,
    ST_WRITTEN  = 3'd1,
    ST_REJECTED = 3'd2,
    ST_EMPTY    = 3'd3,
    ST_VALID    = 3'd4,
    ST_FINISHED = 3'd5
  } status_e;

  typedef struct packed {
    logic [1:0]  operation;
    logic [7:0]  point_index;
    logic [2:0]  joint;
    logic [31:0] time_ms;
    logic [31:0] position;
    logic [31:0] velocity;
    logic [31:0] point_count;
  } in_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [2:0]  joint_out;
    logic [31:0] position_out;
    logic [31:0] velocity_out;
    logic        last;
  } out_t;

  typedef enum logic [1:0] {
    CMD_START  = 2'd0,
    CMD_WRITE  = 2'd1,
    CMD_REJECT = 2'd2,
    CMD_QUERY  = 2'd3
  } cmd_e;

  typedef struct packed {
    cmd_e              kind;
    logic [SlotW-1:0]  offset;
    logic [JointW-1:0] joint;
    logic [31:0]       time_ms;
    logic [31:0]       position;
    logic [31:0]       velocity;
    logic [31:0]       point_count;
  } cmd_t;

endpackage

`default_nettype wire

### src/timed_setpoint_ring_buffer_core.sv
// Top level of the timed setpoint ring buffer: front end, queue and execution engine.
//
//  channel  | handshake                  | payload
//  ---------+----------------------------+-----------------------
//  request  | in_valid_i / in_ready_o    | in_req_i   (in_t)
//  result   | out_valid_o / out_ready_i  | out_rsp_o  (out_t)
//
// Every request passes the front-end register and the queue before the engine takes
// it. A query returns one result per joint, one per cycle while the result register
// is not stalled, paced by the single read port of the goal memory.
// Requests are executed one at a time; a two-entry queue lets new requests be
// accepted while the engine works or the result register is stalled.
// Reset clears the pointers, counters and handshake state; memories need no clearing.
`timescale 1ns / 1ps
`default_nettype none

module timed_setpoint_ring_buffer_core import tsrb_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  in_t  in_req_i,
  output logic out_valid_o,
  input  logic out_ready_i,
  output out_t out_rsp_o
);

  logic fr_valid, fr_ready;
  cmd_t fr_cmd;
  logic bk_valid, bk_ready;
  cmd_t bk_cmd;

  tsrb_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_req_i   (in_req_i),
    .cmd_valid_o(fr_valid),
    .cmd_ready_i(fr_ready),
    .cmd_o      (fr_cmd)
  );

  tsrb_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_valid_i(fr_valid),
    .push_ready_o(fr_ready),
    .push_i      (fr_cmd),
    .pop_valid_o (bk_valid),
    .pop_ready_i (bk_ready),
    .pop_o       (bk_cmd)
  );

  tsrb_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_valid_i(bk_valid),
    .cmd_ready_o(bk_ready),
    .cmd_i      (bk_cmd),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_rsp_o  (out_rsp_o)
  );

endmodule

`default_nettype wire

### src/tsrb_front.sv
// Front end: accepts requests, classifies them and drops unused operation codes.
`timescale 1ns / 1ps
`default_nettype none

module tsrb_front import tsrb_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  in_t  in_req_i,
  output logic cmd_valid_o,
  input  logic cmd_ready_i,
  output cmd_t cmd_o
);

  logic valid_q, valid_d;
  cmd_t cmd_q, cmd_d;
  logic reject;
  logic keep;

  assign in_ready_o  = !valid_q || cmd_ready_i;
  assign cmd_valid_o = valid_q;
  assign cmd_o       = cmd_q;

  always_comb begin
    reject = (32'(in_req_i.point_index) >= 32'(BufferPoints - 1)) ||
             (32'(in_req_i.joint) >= 32'(Joints));
    keep   = 1'b1;
    cmd_d.offset      = in_req_i.point_index[SlotW-1:0];
    cmd_d.joint       = in_req_i.joint;
    cmd_d.time_ms     = in_req_i.time_ms;
    cmd_d.position    = in_req_i.position;
    cmd_d.velocity    = in_req_i.velocity;
    cmd_d.point_count = in_req_i.point_count;
    case (op_e'(in_req_i.operation))
      OP_START: cmd_d.kind = CMD_START;
      OP_WRITE: cmd_d.kind = reject ? CMD_REJECT : CMD_WRITE;
      OP_QUERY: cmd_d.kind = CMD_QUERY;
      default: begin
        cmd_d.kind = CMD_QUERY;
        keep       = 1'b0;
      end
    endcase

    valid_d = valid_q;
    if (in_ready_o) begin
      valid_d = in_valid_i && keep;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      cmd_q <= cmd_d;
    end
  end

endmodule

`default_nettype wire

### src/tsrb_queue.sv
// Small command queue between the front end and the execution engine.
`timescale 1ns / 1ps
`default_nettype none

module tsrb_queue import tsrb_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_valid_i,
  output logic push_ready_o,
  input  cmd_t push_i,
  output logic pop_valid_o,
  input  logic pop_ready_i,
  output cmd_t pop_o
);

  localparam logic [QueuePtrW-1:0] PtrLast = QueuePtrW'(QueueDepth - 1);
  localparam logic [QueueCntW-1:0] CntFull = QueueCntW'(QueueDepth);

  cmd_t                 mem_q [QueueDepth];
  logic [QueuePtrW-1:0] wr_q, rd_q;
  logic [QueueCntW-1:0] cnt_q;
  logic                 push, pop;

  assign push_ready_o = cnt_q != CntFull;
  assign pop_valid_o  = cnt_q != '0;
  assign pop_o        = mem_q[rd_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push) begin
        wr_q <= (wr_q == PtrLast) ? '0 : wr_q + 1'b1;
      end
      if (pop) begin
        rd_q <= (rd_q == PtrLast) ? '0 : rd_q + 1'b1;
      end
      if (push && !pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop && !push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_q] <= push_i;
    end
  end

endmodule

`default_nettype wire

### src/tsrb_back.sv
// Execution engine: ring pointers, point and goal memories, result register.
`timescale 1ns / 1ps
`default_nettype none

module tsrb_back import tsrb_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic cmd_valid_i,
  output logic cmd_ready_o,
  input  cmd_t cmd_i,
  output logic out_valid_o,
  input  logic out_ready_i,
  output out_t out_rsp_o
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_HEAD,
    S_NEXT,
    S_GOAL
  } state_e;

  localparam logic [SlotW:0]    SlotMod   = (SlotW + 1)'(BufferPoints);
  localparam logic [SlotW-1:0]  SlotLast  = SlotW'(BufferPoints - 1);
  localparam logic [JointW-1:0] JointLast = JointW'(Joints - 1);

  function automatic logic [SlotW-1:0] slot_next(input logic [SlotW-1:0] s);
    return (s == SlotLast) ? '0 : s + 1'b1;
  endfunction

  function automatic logic [SlotW-1:0] slot_add(input logic [SlotW-1:0] a,
                                                input logic [SlotW-1:0] b);
    logic [SlotW:0] sum;
    sum = {1'b0, a} + {1'b0, b};
    if (sum >= SlotMod) begin
      sum = sum - SlotMod;
    end
    return sum[SlotW-1:0];
  endfunction

  function automatic out_t short_rsp(input status_e st);
    out_t r;
    r              = '0;
    r.status       = st;
    r.last         = 1'b1;
    return r;
  endfunction

  state_e            state_q;
  cmd_t              cmd_q;
  logic [SlotW-1:0]  head_q, tail_q;
  logic [31:0]       passed_q, total_q;
  logic [JointW-1:0] jnt_q;
  logic              out_valid_q;
  out_t              out_q;

  logic [31:0] time_mem [BufferPoints];
  logic [63:0] goal_mem [GoalDepth];
  logic [31:0] time_rd_q;
  logic [63:0] goal_rd_q;

  logic              can_load;
  logic [SlotW-1:0]  wslot, nslot, head_eff, time_raddr;
  logic [SlotW:0]    fill;
  logic              advance, time_we, time_re, goal_we, goal_re, fin, too_early;
  logic [GoalAw-1:0] goal_waddr, goal_raddr, goal_base;
  logic [JointW-1:0] rd_jnt;

  assign cmd_ready_o = state_q == S_IDLE;
  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_q;

  always_comb begin
    can_load  = !out_valid_q || out_ready_i;
    wslot     = slot_add(head_q, cmd_q.offset);
    nslot     = slot_next(head_q);
    fill      = (tail_q >= head_q) ? {1'b0, tail_q - head_q}
                                   : ({1'b0, tail_q} + SlotMod - {1'b0, head_q});
    too_early = cmd_q.time_ms < time_rd_q;
    advance   = (state_q == S_NEXT) && !too_early;
    head_eff  = advance ? nslot : head_q;
    goal_base = GoalAw'(int'(head_eff) * Joints);
    fin       = (total_q != '0) && (passed_q == total_q - 32'd1);

    time_we    = (state_q == S_EXEC) && (cmd_q.kind == CMD_WRITE) && can_load;
    goal_we    = time_we;
    goal_waddr = GoalAw'(int'(wslot) * Joints + int'(cmd_q.joint));

    time_re    = 1'b0;
    time_raddr = head_q;
    goal_re    = 1'b0;
    rd_jnt     = '0;
    case (state_q)
      S_EXEC: begin
        time_re = (cmd_q.kind == CMD_QUERY) && (fill != '0);
      end
      S_HEAD: begin
        if (!too_early) begin
          if (fill > (SlotW + 1)'(1)) begin
            time_re    = 1'b1;
            time_raddr = nslot;
          end else begin
            goal_re = 1'b1;
          end
        end
      end
      S_NEXT: begin
        goal_re = 1'b1;
      end
      S_GOAL: begin
        // prefetch the next joint while the current one is handed out
        if (can_load && (jnt_q != JointLast)) begin
          goal_re = 1'b1;
          rd_jnt  = jnt_q + 1'b1;
        end
      end
      default: ;
    endcase
    goal_raddr = goal_base + GoalAw'(rd_jnt);
  end

  always_ff @(posedge clk_i) begin
    if (time_we) begin
      time_mem[wslot] <= cmd_q.time_ms;
    end
    if (time_re) begin
      time_rd_q <= time_mem[time_raddr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (goal_we) begin
      goal_mem[goal_waddr] <= {cmd_q.velocity, cmd_q.position};
    end
    if (goal_re) begin
      goal_rd_q <= goal_mem[goal_raddr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cmd_q       <= '0;
      head_q      <= '0;
      tail_q      <= '0;
      passed_q    <= '0;
      total_q     <= '0;
      jnt_q       <= '0;
      out_valid_q <= 1'b0;
      out_q       <= '0;
    end else begin
      if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (cmd_valid_i) begin
            cmd_q   <= cmd_i;
            state_q <= S_EXEC;
          end
        end
        S_EXEC: begin
          case (cmd_q.kind)
            CMD_START: begin
              if (can_load) begin
                head_q      <= '0;
                tail_q      <= '0;
                passed_q    <= '0;
                total_q     <= cmd_q.point_count;
                out_valid_q <= 1'b1;
                out_q       <= short_rsp(ST_STARTED);
                state_q     <= S_IDLE;
              end
            end
            CMD_WRITE: begin
              if (can_load) begin
                tail_q      <= slot_next(wslot);
                out_valid_q <= 1'b1;
                out_q       <= short_rsp(ST_WRITTEN);
                state_q     <= S_IDLE;
              end
            end
            CMD_REJECT: begin
              if (can_load) begin
                out_valid_q <= 1'b1;
                out_q       <= short_rsp(ST_REJECTED);
                state_q     <= S_IDLE;
              end
            end
            default: begin
              if (fill == '0) begin
                if (can_load) begin
                  out_valid_q <= 1'b1;
                  out_q       <= short_rsp(ST_EMPTY);
                  state_q     <= S_IDLE;
                end
              end else begin
                state_q <= S_HEAD;
              end
            end
          endcase
        end
        S_HEAD: begin
          if (too_early) begin
            if (can_load) begin
              out_valid_q <= 1'b1;
              out_q       <= short_rsp(ST_EMPTY);
              state_q     <= S_IDLE;
            end
          end else if (fill > (SlotW + 1)'(1)) begin
            state_q <= S_NEXT;
          end else begin
            jnt_q   <= '0;
            state_q <= S_GOAL;
          end
        end
        S_NEXT: begin
          if (advance) begin
            head_q   <= nslot;
            passed_q <= passed_q + 32'd1;
          end
          jnt_q   <= '0;
          state_q <= S_GOAL;
        end
        S_GOAL: begin
          if (can_load) begin
            out_valid_q        <= 1'b1;
            out_q.joint_out    <= jnt_q;
            out_q.position_out <= goal_rd_q[31:0];
            out_q.velocity_out <= goal_rd_q[63:32];
            if (jnt_q == JointLast) begin
              out_q.status <= fin ? ST_FINISHED : ST_VALID;
              out_q.last   <= 1'b1;
              state_q      <= S_IDLE;
            end else begin
              out_q.status <= ST_VALID;
              out_q.last   <= 1'b0;
              jnt_q        <= jnt_q + 1'b1;
            end
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // a stored write always leaves at least one point in the ring
  a_write_fills: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_EXEC && cmd_q.kind == CMD_WRITE && can_load) |=> tail_q != head_q)
    else $error("ring empty after write");

  a_next_needs_two: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_NEXT) |-> (fill > (SlotW + 1)'(1)))
    else $error("head advance checked with fewer than two points");

  a_last_joint: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_GOAL && can_load && jnt_q == JointLast) |=>
      (state_q == S_IDLE && out_valid_q && out_q.last))
    else $error("final joint result not flagged last");

  a_pop_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_valid_i && cmd_ready_o) |=> state_q == S_EXEC)
    else $error("queued request not taken into execution");

endmodule

`default_nettype wire

### tb/sv/timed_setpoint_ring_buffer_core_tb.sv
// Self-checking testbench for the timed setpoint ring buffer core.
`timescale 1ns / 1ps

module timed_setpoint_ring_buffer_core_tb;
  import tsrb_pkg::*;

  localparam int RandItems   = 300;
  localparam int StallLimit  = 1000;
  localparam int DrainCycles = 30;

  typedef struct {
    in_t     req;
    bit      typed;
    status_e st;
  } dir_row_t;

  logic clk_i;
  logic rst_ni;
  logic in_valid_i;
  logic in_ready_o;
  in_t  in_req_i;
  logic out_valid_o;
  logic out_ready_i;
  out_t out_rsp_o;

  timed_setpoint_ring_buffer_core DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_req_i   (in_req_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_rsp_o  (out_rsp_o)
  );

  // Shadow copy of the buffer contents and pointers
  logic [31:0]      pt_time  [BufferPoints];
  logic [63:0]      goal_mem [GoalDepth];
  bit               time_set [BufferPoints];
  bit               goal_set [GoalDepth];
  logic [SlotW-1:0] ring_head = '0;
  logic [SlotW-1:0] ring_tail = '0;
  logic [31:0]      passed_pts = '0;
  logic [31:0]      total_pts  = '0;

  out_t     step_rsp_q[$];
  out_t     awaited_rsp_q[$];
  dir_row_t dir_tab[$];
  out_t     exp_rsp;

  int src_gap_max  = 6;
  int sink_gap_max = 6;
  int err_cnt      = 0;
  int quiet_cycles = 0;
  int n_req        = 0;
  int n_rsp        = 0;
  int n_fin        = 0;
  int n_empty      = 0;
  int n_rej        = 0;
  int n_advance    = 0;
  int n_wraps      = 0;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic logic [SlotW-1:0] ring_fill();
    return ring_tail - ring_head;
  endfunction

  function automatic void predict_setpoints(input in_t req);
    logic [SlotW-1:0] slot;
    logic [SlotW-1:0] nxt;
    logic [SlotW-1:0] fill;
    bit               finishing;
    out_t             r;
    int               j;
    step_rsp_q.delete();
    r = '0;
    r.last = 1'b1;
    case (op_e'(req.operation))
      OP_START: begin
        ring_head  = '0;
        ring_tail  = '0;
        passed_pts = '0;
        total_pts  = req.point_count;
        r.status   = ST_STARTED;
        step_rsp_q.push_back(r);
      end
      OP_WRITE: begin
        if (req.point_index >= BufferPoints - 1 || req.joint >= Joints) begin
          r.status = ST_REJECTED;
        end else begin
          slot = ring_head + req.point_index[SlotW-1:0];
          pt_time[slot]  = req.time_ms;
          time_set[slot] = 1'b1;
          goal_mem[slot * Joints + req.joint] = {req.velocity, req.position};
          goal_set[slot * Joints + req.joint] = 1'b1;
          ring_tail = slot + 1'b1;
          r.status  = ST_WRITTEN;
        end
        step_rsp_q.push_back(r);
      end
      OP_QUERY: begin
        fill = ring_fill();
        if (fill == 0 || req.time_ms < pt_time[ring_head]) begin
          r.status = ST_EMPTY;
          step_rsp_q.push_back(r);
        end else begin
          nxt = ring_head + 1'b1;
          if (fill > 1 && req.time_ms >= pt_time[nxt]) begin
            ring_head  = nxt;
            passed_pts = passed_pts + 1;
            n_advance++;
            if (nxt == 0) n_wraps++;
          end
          finishing = (total_pts != 0) && (passed_pts == total_pts - 1);
          for (j = 0; j < Joints; j++) begin
            r.status       = (j == Joints - 1 && finishing) ? ST_FINISHED : ST_VALID;
            r.joint_out    = 3'(j);
            r.position_out = goal_mem[ring_head * Joints + j][31:0];
            r.velocity_out = goal_mem[ring_head * Joints + j][63:32];
            r.last         = (j == Joints - 1);
            step_rsp_q.push_back(r);
          end
        end
      end
      default: ;  // unused code: dropped silently
    endcase
  endfunction

  // True when a query at tm touches only stored entries, next point time included
  function automatic bit query_reads_defined(input logic [31:0] tm);
    logic [SlotW-1:0] fill;
    logic [SlotW-1:0] nxt;
    logic [SlotW-1:0] hd;
    int               j;
    fill = ring_fill();
    if (fill == 0) return 1'b1;
    nxt = ring_head + 1'b1;
    if (!time_set[ring_head]) return 1'b0;
    if (fill > 1 && !time_set[nxt]) return 1'b0;
    if (tm < pt_time[ring_head]) return 1'b1;
    hd = (fill > 1 && tm >= pt_time[nxt]) ? nxt : ring_head;
    for (j = 0; j < Joints; j++) begin
      if (!goal_set[hd * Joints + j]) return 1'b0;
    end
    return 1'b1;
  endfunction

  function automatic in_t random_req(input op_e op);
    in_t r;
    r.operation   = op;
    r.point_index = 8'($urandom);
    r.joint       = 3'($urandom);
    r.time_ms     = $urandom;
    r.position    = $urandom;
    r.velocity    = $urandom;
    r.point_count = $urandom;
    return r;
  endfunction

  function automatic dir_row_t dir_row(input op_e op, input logic [7:0] idx,
                                       input logic [2:0] jt, input logic [31:0] tm,
                                       input logic [31:0] pos, input logic [31:0] vel,
                                       input logic [31:0] cnt, input bit typed,
                                       input status_e st);
    dir_row_t row;
    row.req.operation   = op;
    row.req.point_index = idx;
    row.req.joint       = jt;
    row.req.time_ms     = tm;
    row.req.position    = pos;
    row.req.velocity    = vel;
    row.req.point_count = cnt;
    row.typed           = typed;
    row.st              = st;
    return row;
  endfunction

  task automatic send_request(input in_t req, input bit typed, input status_e typed_st);
    int   gap;
    out_t r;
    gap = $urandom_range(0, src_gap_max);
    @(negedge clk_i);
    if (gap != 0) begin
      in_valid_i = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_req_i   = req;
    in_valid_i = 1'b1;
    do @(posedge clk_i); while (!in_ready_o);
    predict_setpoints(req);
    if (op_e'(req.operation) != OP_UNUSED) n_req++;
    if (typed) begin
      r = '0;
      r.status = typed_st;
      r.last   = 1'b1;
      awaited_rsp_q.push_back(r);
    end else begin
      foreach (step_rsp_q[i]) awaited_rsp_q.push_back(step_rsp_q[i]);
    end
  endtask

  task automatic hold_off_until_drained();
    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (awaited_rsp_q.size() != 0) @(posedge clk_i);
  endtask

  // One full point: every joint goal at the next free offset, same point time
  task automatic write_point(input logic [31:0] t);
    in_t        req;
    logic [7:0] idx;
    int         first;
    int         k;
    idx   = 8'(ring_fill());
    first = $urandom_range(0, Joints - 1);
    for (k = 0; k < Joints; k++) begin
      req = random_req(OP_WRITE);
      req.point_index = idx;
      req.joint       = 3'((first + k) % Joints);
      req.time_ms     = t;
      send_request(req, 1'b0, ST_WRITTEN);
    end
  endtask

  task automatic query_near_head();
    in_t         req;
    logic [31:0] th;
    logic [31:0] tn;
    logic [31:0] tm;
    req = random_req(OP_QUERY);
    if (ring_fill() == 0) begin
      tm = $urandom;
    end else begin
      th = pt_time[ring_head];
      tn = (ring_fill() > 1) ? pt_time[SlotW'(ring_head + 1'b1)] : th;
      case ($urandom_range(0, 5))
        0:       tm = th - 1;
        1:       tm = th;
        2, 3:    tm = tn;
        4:       tm = tn + $urandom_range(0, 20);
        default: tm = $urandom;
      endcase
      if (!query_reads_defined(tm)) tm = th;
    end
    req.time_ms = tm;
    if (query_reads_defined(tm)) send_request(req, 1'b0, ST_VALID);
  endtask

  // Rejected writes, dropped codes, or a rewrite that pulls the tail back
  task automatic send_broken_item();
    in_t              req;
    int               fill_n;
    logic [SlotW-1:0] slot;
    req = random_req(OP_WRITE);
    case ($urandom_range(0, 3))
      0: req.point_index = 8'($urandom_range(BufferPoints - 1, 255));
      1: req.joint = 3'($urandom_range(Joints, 7));
      2: req.operation = OP_UNUSED;
      default: begin
        fill_n = int'(ring_fill());
        if (fill_n == 0) begin
          req.operation = OP_UNUSED;
        end else begin
          req.point_index = 8'($urandom_range(0, fill_n - 1));
          req.joint       = 3'($urandom_range(0, Joints - 1));
          slot = ring_head + req.point_index[SlotW-1:0];
          if (time_set[slot]) req.time_ms = pt_time[slot];
        end
      end
    endcase
    send_request(req, 1'b0, ST_REJECTED);
  endtask

  task automatic run_trajectory(input int npts);
    in_t         req;
    logic [31:0] t;
    int          written;
    int          steps;
    req = random_req(OP_START);
    case ($urandom_range(0, 9))
      0:       req.point_count = '0;
      1:       req.point_count = $urandom;
      2:       req.point_count = npts + $urandom_range(1, 3);
      default: req.point_count = npts;
    endcase
    send_request(req, 1'b0, ST_STARTED);
    t       = $urandom_range(0, 32'hFFFF_0000);
    written = 0;
    steps   = 0;
    while ((written < npts || ring_fill() > 1) && steps < 400) begin
      steps++;
      if (written < npts && ring_fill() < BufferPoints - 1 &&
          (ring_fill() < 2 || $urandom_range(0, 2) != 0)) begin
        t = t + $urandom_range(1, 40);
        write_point(t);
        written++;
      end else begin
        query_near_head();
      end
      if ($urandom_range(0, 11) == 0) send_broken_item();
    end
    query_near_head();
  endtask

  task automatic send_noise();
    in_t req;
    req = random_req(op_e'($urandom_range(0, 3)));
    if (op_e'(req.operation) == OP_WRITE && $urandom_range(0, 1) == 1)
      req.point_index = 8'($urandom_range(0, 16));
    if (op_e'(req.operation) == OP_QUERY && !query_reads_defined(req.time_ms))
      req.operation = OP_UNUSED;
    send_request(req, 1'b0, ST_STARTED);
  endtask

  initial begin : stimulus
    int          p;
    int          j;
    int          base;
    int          blk;
    int          n;
    logic [31:0] pos;
    logic [31:0] vel;
    in_valid_i = 1'b0;
    in_req_i   = '0;
    rst_ni     = 1'b0;

    dir_tab.push_back(dir_row(OP_QUERY, 8'd0, 3'd0, 32'd0, $urandom, $urandom,
                              $urandom, 1'b1, ST_EMPTY));
    dir_tab.push_back(dir_row(OP_WRITE, 8'd15, 3'd0, $urandom, $urandom, $urandom,
                              $urandom, 1'b1, ST_REJECTED));
    dir_tab.push_back(dir_row(OP_WRITE, 8'd255, 3'd5, $urandom, $urandom, $urandom,
                              $urandom, 1'b1, ST_REJECTED));
    dir_tab.push_back(dir_row(OP_WRITE, 8'd0, 3'd6, $urandom, $urandom, $urandom,
                              $urandom, 1'b1, ST_REJECTED));
    dir_tab.push_back(dir_row(OP_WRITE, 8'd0, 3'd7, $urandom, $urandom, $urandom,
                              $urandom, 1'b1, ST_REJECTED));
    dir_tab.push_back(dir_row(OP_UNUSED, 8'd0, 3'd0, $urandom, $urandom, $urandom,
                              $urandom, 1'b0, ST_STARTED));
    dir_tab.push_back(dir_row(OP_START, 8'($urandom), 3'($urandom), $urandom, $urandom,
                              $urandom, 32'd2, 1'b1, ST_STARTED));
    for (p = 0; p < 2; p++) begin
      for (j = 0; j < Joints; j++) begin
        pos = $urandom;
        vel = $urandom;
        if (p == 0 && j == 0) begin pos = '0; vel = '1; end
        if (p == 1 && j == Joints - 1) begin pos = '1; vel = '0; end
        dir_tab.push_back(dir_row(OP_WRITE, 8'(p), 3'(j),
                                  (p == 0) ? 32'd100 : 32'hFFFF_FFFF,
                                  pos, vel, $urandom, 1'b1, ST_WRITTEN));
      end
    end
    // before the head point, at it, at the last point (finishes), then behind it
    dir_tab.push_back(dir_row(OP_QUERY, 8'($urandom), 3'($urandom), 32'd99, $urandom,
                              $urandom, $urandom, 1'b1, ST_EMPTY));
    dir_tab.push_back(dir_row(OP_QUERY, 8'($urandom), 3'($urandom), 32'd100, $urandom,
                              $urandom, $urandom, 1'b0, ST_VALID));
    dir_tab.push_back(dir_row(OP_QUERY, 8'($urandom), 3'($urandom), 32'hFFFF_FFFF,
                              $urandom, $urandom, $urandom, 1'b0, ST_FINISHED));
    dir_tab.push_back(dir_row(OP_QUERY, 8'($urandom), 3'($urandom), 32'd100, $urandom,
                              $urandom, $urandom, 1'b1, ST_EMPTY));
    dir_tab.push_back(dir_row(OP_START, 8'($urandom), 3'($urandom), $urandom, $urandom,
                              $urandom, 32'hFFFF_FFFF, 1'b1, ST_STARTED));
    dir_tab.push_back(dir_row(OP_QUERY, 8'($urandom), 3'($urandom), 32'hFFFF_FFFF,
                              $urandom, $urandom, $urandom, 1'b1, ST_EMPTY));

    repeat (7) @(negedge clk_i);
    rst_ni = 1'b1;

    foreach (dir_tab[i]) send_request(dir_tab[i].req, dir_tab[i].typed, dir_tab[i].st);
    hold_off_until_drained();

    base = n_req;
    blk  = 0;
    while (n_req - base < RandItems) begin
      src_gap_max  = ($urandom_range(0, 3) == 0) ? 0 : 6;
      sink_gap_max = ($urandom_range(0, 3) == 0) ? 0 : 6;
      if (blk != 0 && $urandom_range(0, 3) == 0) hold_off_until_drained();
      if (blk == 0) begin
        run_trajectory(BufferPoints + 2);  // long enough to wrap the ring
      end else if ($urandom_range(0, 2) != 0) begin
        run_trajectory(($urandom_range(0, 7) == 0) ? $urandom_range(15, 20)
                                                   : $urandom_range(1, 6));
      end else begin
        for (n = $urandom_range(1, 4); n > 0; n--) send_noise();
      end
      blk++;
    end

    hold_off_until_drained();
    repeat (DrainCycles) @(posedge clk_i);

    $display("Covered %0d requests and %0d results: %0d finished, %0d empty, %0d rejected.",
             n_req, n_rsp, n_fin, n_empty, n_rej);
    $display("Head advanced %0d times, wrapping the ring %0d times; %0d mismatches.",
             n_advance, n_wraps, err_cnt);
    if (err_cnt == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin : result_sink
    int gap;
    out_ready_i = 1'b0;
    forever begin
      gap = $urandom_range(0, sink_gap_max);
      @(negedge clk_i);
      if (gap != 0) begin
        out_ready_i = 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      out_ready_i = 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
    end
  end

  task automatic report_field(input string name, input logic [31:0] exp_v,
                              input logic [31:0] act_v);
    err_cnt++;
    $display("%0t: %s mismatch: expected %0h, got %0h", $time, name, exp_v, act_v);
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (awaited_rsp_q.size() == 0) begin
        err_cnt++;
        $display("%0t: result with no request outstanding: expected none, got %h",
                 $time, out_rsp_o);
      end else begin
        exp_rsp = awaited_rsp_q.pop_front();
        if (out_rsp_o.status !== exp_rsp.status)
          report_field("status", 32'(exp_rsp.status), 32'(out_rsp_o.status));
        if (out_rsp_o.joint_out !== exp_rsp.joint_out)
          report_field("joint_out", 32'(exp_rsp.joint_out), 32'(out_rsp_o.joint_out));
        if (out_rsp_o.position_out !== exp_rsp.position_out)
          report_field("position_out", exp_rsp.position_out, out_rsp_o.position_out);
        if (out_rsp_o.velocity_out !== exp_rsp.velocity_out)
          report_field("velocity_out", exp_rsp.velocity_out, out_rsp_o.velocity_out);
        if (out_rsp_o.last !== exp_rsp.last)
          report_field("last", 32'(exp_rsp.last), 32'(out_rsp_o.last));
        n_rsp++;
        case (status_e'(exp_rsp.status))
          ST_FINISHED: n_fin++;
          ST_EMPTY:    n_empty++;
          ST_REJECTED: n_rej++;
          default: ;
        endcase
      end
    end
  end

  // Watchdog: any handshake on either side counts as progress
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles == StallLimit) begin
        $display("%0t: no handshake for %0d cycles", $time, StallLimit);
        $display("TB_ERROR");
        $finish;
      end
    end
  end

endmodule
